// ===== rtl/core/atif_pkg.sv =====
`default_nettype none

package atif_pkg;

    // table geometry
    localparam int TABLE_DEPTH   = 16;
    localparam int ADDRESS_WIDTH = 16;
    localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

    // item field widths
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int ENTRY_W  = 5;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    cluster_address;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [ENTRY_W-1:0]  entry_count;
    } t_result;

    // per-cell update command
    typedef struct packed {
        logic write;
        logic remove;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/address_table_insert_find_remove.sv =====
// The result strobe o_valid rises in the cycle after an item is accepted.
// One item per cycle; busy is never raised, since the row of cells
// compares, appends and shifts the whole table at once.
// o_valid is high for a single cycle per result; o_result keeps it until the next item is accepted.
// Reset (synchronous, active low) empties the table; entry contents are
// undefined until written.
`default_nettype none

module address_table_insert_find_remove import atif_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_valid;
    t_result                  r_result;
    t_result                  n_result;

    logic                     w_accept;
    logic [ADDRESS_WIDTH-1:0] w_key;
    logic [TABLE_DEPTH-1:0]   w_match;
    logic [TABLE_DEPTH-1:0]   w_seen;
    logic [ADDRESS_WIDTH-1:0] w_addr [TABLE_DEPTH];
    logic                     w_hit;
    logic [IDX_W-1:0]         w_hit_idx;
    logic                     w_create_ok;
    logic                     w_remove_ok;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_key    = ADDRESS_WIDTH'(i_item.cluster_address);
    assign w_hit    = |w_match;

    assign w_create_ok = w_accept && (i_item.action == ACT_CREATE)
                         && (r_count < CNT_W'(TABLE_DEPTH)) && !w_hit;
    assign w_remove_ok = w_accept && (i_item.action == ACT_REMOVE) && w_hit;

    // row of cells, match chain runs from slot 0 upward
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic                     w_seen_in;
        logic [ADDRESS_WIDTH-1:0] w_next;
        t_cell_ctl                w_ctl;

        if (g == 0) begin : g_first
            assign w_seen_in = 1'b0;
        end else begin : g_mid
            assign w_seen_in = w_seen[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_addr[g+1];
        end

        assign w_ctl.write  = w_create_ok && (r_count == CNT_W'(g));
        assign w_ctl.remove = w_remove_ok;

        atif_cell u_cell (
            .i_clk       (i_clk),
            .i_key       (w_key),
            .i_next_addr (w_next),
            .i_valid     (CNT_W'(g) < r_count),
            .i_seen      (w_seen_in),
            .i_ctl       (w_ctl),
            .o_match     (w_match[g]),
            .o_seen      (w_seen[g]),
            .o_addr      (w_addr[g])
        );
    end

    // encode the matching slot, at most one cell matches
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | IDX_W'(i);
            end
        end
    end

    // result and count update
    always_comb begin
        n_count             = r_count;
        n_result.status     = ST_ABSENT;
        n_result.slot_index = '0;
        case (i_item.action)
            ACT_CREATE: begin
                if (w_create_ok) begin
                    n_count             = r_count + CNT_W'(1);
                    n_result.status     = ST_OK;
                    n_result.slot_index = SLOT_W'(r_count);
                end else begin
                    n_result.status = ST_REJECT;
                end
            end
            ACT_FIND: begin
                if (w_hit) begin
                    n_result.status     = ST_OK;
                    n_result.slot_index = SLOT_W'(w_hit_idx);
                end
            end
            ACT_REMOVE: begin
                if (w_hit) begin
                    n_count         = r_count - CNT_W'(1);
                    n_result.status = ST_OK;
                end
            end
            default: begin
                n_result.status = ST_ABSENT;
            end
        endcase
        if (!w_accept) begin
            n_count = r_count;
        end
        n_result.entry_count = ENTRY_W'(n_count);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("address present in more than one slot");

    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.entry_count == ENTRY_W'(r_count)))
        else $error("reported entry count differs from table");

    a_strobe_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted item gave no result");

endmodule

`default_nettype wire

// ===== rtl/core/atif_cell.sv =====
`default_nettype none

module atif_cell import atif_pkg::*; (
    input  logic                     i_clk,
    input  logic [ADDRESS_WIDTH-1:0] i_key,
    input  logic [ADDRESS_WIDTH-1:0] i_next_addr,
    input  logic                     i_valid,
    input  logic                     i_seen,
    input  t_cell_ctl                i_ctl,
    output logic                     o_match,
    output logic                     o_seen,
    output logic [ADDRESS_WIDTH-1:0] o_addr
);

    logic [ADDRESS_WIDTH-1:0] r_addr;
    logic [ADDRESS_WIDTH-1:0] n_addr;

    // compare against the key and pass the match on up the row
    assign o_match = i_valid && (r_addr == i_key);
    assign o_seen  = i_seen || o_match;
    assign o_addr  = r_addr;

    // load the key, take the upper neighbor on a remove at or above the match, or hold
    always_comb begin
        n_addr = r_addr;
        if (i_ctl.write) begin
            n_addr = i_key;
        end else if (i_ctl.remove && o_seen) begin
            n_addr = i_next_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

endmodule

`default_nettype wire

// ===== tb/address_table_insert_find_remove_test.sv =====
`timescale 1ns / 1ps

module address_table_insert_find_remove_test;
    import atif_pkg::*;

    // code the block must treat as a no-op
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MASK = (ADDRESS_WIDTH >= KEY_W) ?
        {KEY_W{1'b1}} : KEY_W'((64'd1 << ADDRESS_WIDTH) - 64'd1);
    localparam int POOL_SIZE = 24;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_valid;
    t_result o_result;

    // predicted table contents and fill level
    logic [KEY_W-1:0] addr_slots [TABLE_DEPTH];
    int               slot_fill;

    t_result          pending_results [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               error_count;
    bit               gap_free;

    address_table_insert_find_remove u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // applies one item to the predicted table and returns its result
    function automatic t_result apply_table_op(t_item it);
        t_result          r;
        logic [KEY_W-1:0] key;
        int               hit;
        key = it.cluster_address & KEY_MASK;
        hit = -1;
        for (int i = 0; i < slot_fill; i++) begin
            if (hit < 0 && addr_slots[i] == key) begin
                hit = i;
            end
        end
        r.status     = ST_ABSENT;
        r.slot_index = '0;
        case (it.action)
            ACT_CREATE: begin
                if (slot_fill < TABLE_DEPTH && hit < 0) begin
                    addr_slots[slot_fill] = key;
                    r.slot_index = SLOT_W'(slot_fill);
                    slot_fill++;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_REJECT;
                end
            end
            ACT_FIND: begin
                if (hit >= 0) begin
                    r.slot_index = SLOT_W'(hit);
                    r.status = ST_OK;
                end
            end
            ACT_REMOVE: begin
                if (hit >= 0) begin
                    // later entries close the gap, order kept
                    for (int i = hit; i < slot_fill - 1; i++) begin
                        addr_slots[i] = addr_slots[i + 1];
                    end
                    slot_fill--;
                    r.status = ST_OK;
                end
            end
            default: begin
            end
        endcase
        r.entry_count = ENTRY_W'(slot_fill);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < 100) begin
            $display("%0t mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    // sends one item, each cycle in front of it idle at random unless gap_free is set
    task automatic send_op(input logic [ACTION_W-1:0] action, input logic [KEY_W-1:0] key);
        t_item it;
        it.action = action;
        it.cluster_address = key;
        if (!gap_free) begin
            while ($urandom_range(99) < 31) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_table_op(it));
    endtask

    // sender holds off until every result is back
    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic refresh_key_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = KEY_W'($urandom);
        end
    endtask

    // mostly keys from a small pool so that hits, duplicates and full tables happen
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 88) begin
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return KEY_W'($urandom);
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(input int create_pct,
                                                        input int remove_pct);
        int r;
        r = $urandom_range(99);
        if (r < create_pct) begin
            return ACT_CREATE;
        end
        if (r < create_pct + remove_pct) begin
            return ACT_REMOVE;
        end
        if (r < 96) begin
            return ACT_FIND;
        end
        return ACT_UNUSED;
    endfunction

    // extremes, every action and every reject / miss case, then a full table
    task automatic test_directed();
        send_op(ACT_CREATE, 16'h0000);
        send_op(ACT_CREATE, 16'hFFFF);
        send_op(ACT_FIND, 16'hFFFF);
        send_op(ACT_FIND, 16'h5555);
        send_op(ACT_CREATE, 16'h0000);
        send_op(ACT_UNUSED, 16'hFFFF);
        send_op(ACT_REMOVE, 16'h5555);
        send_op(ACT_REMOVE, 16'h0000);
        send_op(ACT_FIND, 16'hFFFF);
        for (int i = 1; i < TABLE_DEPTH; i++) begin
            send_op(ACT_CREATE, KEY_W'(16'h0101 * i));
        end
        send_op(ACT_CREATE, 16'hAAAA);
        send_op(ACT_FIND, 16'h0F0F);
        send_op(ACT_REMOVE, 16'h0808);
    endtask

    // repeated fill and drain rounds with fresh keys each round
    task automatic test_fill_drain(input int rounds);
        for (int r = 0; r < rounds; r++) begin
            refresh_key_pool();
            repeat (50) send_op(pick_action(70, 10), pick_key());
            repeat (50) send_op(pick_action(10, 70), pick_key());
        end
    endtask

    // balanced mix with the sender never idling
    task automatic test_back_to_back(input int count);
        gap_free = 1'b1;
        refresh_key_pool();
        repeat (count) send_op(pick_action(35, 30), pick_key());
        gap_free = 1'b0;
    endtask

    // balanced mix with random gaps
    task automatic test_random_mix(input int count);
        refresh_key_pool();
        repeat (count) send_op(pick_action(35, 30), pick_key());
    endtask

    // result check, oldest expectation first
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_result.status, want.status));
                end
                if (o_result.slot_index !== want.slot_index) begin
                    report_mismatch($sformatf("slot_index %0d, expected %0d",
                                              o_result.slot_index, want.slot_index));
                end
                if (o_result.entry_count !== want.entry_count) begin
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              o_result.entry_count, want.entry_count));
                end
            end
        end
    end

    initial begin
        error_count = 0;
        gap_free    = 1'b0;
        slot_fill   = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        wait_for_results();
        test_fill_drain(6);
        test_back_to_back(200);
        wait_for_results();
        test_random_mix(350);

        // drain and let the pipeline settle
        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/atif_pkg.sv
rtl/core/atif_cell.sv
rtl/core/address_table_insert_find_remove.sv
tb/address_table_insert_find_remove_test.sv
